[rtl/es2d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package es2d_pkg;

    // Width of the accumulator and of the shared compare-subtract unit.
    localparam int unsigned W_ACC = 32;

    // Calendar constants.
    localparam logic [11:0] C_EPOCH_YEAR = 12'd1970;
    localparam logic [11:0] C_NONLEAP_CENTURY = 12'd2100;
    localparam logic [8:0]  C_DAYS_YEAR = 9'd365;
    localparam logic [8:0]  C_DAYS_LEAP_YEAR = 9'd366;

    // Reciprocals for the divisions by constants. Each is rounded up, and the
    // rounding error is small enough that the quotient is exact over the whole
    // range of its operand. Days come from the seconds shifted right by 7
    // (divisor 675, quotient from bit 35 up), hours from the seconds of the day
    // shifted right by 4 (divisor 225, quotient from bit 21 up), and minutes
    // from the seconds of the hour shifted right by 2 (divisor 15, quotient
    // from bit 14 up).
    localparam logic [25:0] C_RCP_DAY  = 26'd50903317;
    localparam logic [25:0] C_RCP_HOUR = 26'd9321;
    localparam logic [25:0] C_RCP_MIN  = 26'd1093;

    // Seconds per day, hour and minute, for the remainders.
    localparam logic [25:0] C_SECS_DAY  = 26'd86400;
    localparam logic [25:0] C_SECS_HOUR = 26'd3600;
    localparam logic [25:0] C_SECS_MIN  = 26'd60;

    // Leap year test. Within 1970..2106 the only century years are 2000, which
    // is divisible by 400, and 2100, which is not, so the full Gregorian rule
    // reduces to this.
    function automatic logic f_is_leap(input logic [11:0] year);
        f_is_leap = (year[1:0] == 2'b00) && (year != C_NONLEAP_CENTURY);
    endfunction

    // Length of a month, with February at 29 days in a leap year.
    function automatic logic [4:0] f_month_len(input logic [3:0] month, input logic leap);
        case (month)
            4'd2: begin
                f_month_len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                f_month_len = 5'd30;
            end
            default: begin
                f_month_len = 5'd31;
            end
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/epoch_seconds_to_date.sv]
`timescale 1ns / 1ps
`default_nettype none

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// second, minute, hour, day of month, month and year, one item at a time. All
// arithmetic goes through one 32-bit compare-subtract unit and one multiplier
// under a small sequencer: whole days, hours and minutes are each found by a
// reciprocal multiplication and their remainders by a multiply and subtract;
// then whole years are removed one at a time (up to 136) until the next no
// longer fits, and then whole months (up to 11) until the next no longer fits
// or December is reached. o_in_stall is high from acceptance until the
// finished item is loaded into the output register, where it waits, so the
// next item can be accepted while it is still stalled. Register 0 (byte
// address 0) bit 0 selects 12-hour mode with the PM flag; the user must write
// it only while idle, and the block itself does not enforce this.

module epoch_seconds_to_date (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_epoch_seconds,
    // Output channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [5:0]       o_second,
    output logic [5:0]       o_minute,
    output logic [4:0]       o_hour,
    output logic             o_pm_flag,
    output logic [4:0]       o_day_of_month,
    output logic [3:0]       o_month_number,
    output logic [11:0]      o_year_number
);
    import es2d_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DAY      = 4'd1;
    localparam logic [3:0] S_DAY_REM  = 4'd2;
    localparam logic [3:0] S_HOUR     = 4'd3;
    localparam logic [3:0] S_HOUR_REM = 4'd4;
    localparam logic [3:0] S_MIN      = 4'd5;
    localparam logic [3:0] S_MIN_REM  = 4'd6;
    localparam logic [3:0] S_YEAR     = 4'd7;
    localparam logic [3:0] S_MONTH    = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic              r_twelve;
    logic [3:0]        r_state, n_state;
    logic [W_ACC-1:0]  r_acc, n_acc;
    logic [15:0]       r_days, n_days;
    logic [4:0]        r_hour, n_hour;
    logic [5:0]        r_min, n_min;
    logic [5:0]        r_sec, n_sec;
    logic [11:0]       r_year, n_year;
    logic [3:0]        r_month, n_month;

    logic              r_out_valid;
    logic [5:0]        r_o_sec, r_o_min;
    logic [4:0]        r_o_hour, r_o_day;
    logic              r_o_pm;
    logic [3:0]        r_o_month;
    logic [11:0]       r_o_year;

    logic [24:0]       w_mul_a;
    logic [25:0]       w_mul_b;
    logic [50:0]       w_prod;
    logic [W_ACC-1:0]  w_oper;
    logic              w_ge;
    logic [W_ACC-1:0]  w_diff;
    logic              w_leap;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_cfg_wr;

    // Configuration register.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {31'd0, r_twelve} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_twelve <= 1'b0;
        end else if (w_cfg_wr) begin
            r_twelve <= pwdata[0];
        end
    end

    // Operand selection for the shared multiplier: a reciprocal multiplication
    // for each quotient, then the quotient times its divisor for the remainder.
    always_comb begin
        case (r_state)
            S_DAY: begin
                w_mul_a = r_acc[31:7];
                w_mul_b = C_RCP_DAY;
            end
            S_DAY_REM: begin
                w_mul_a = 25'(r_days);
                w_mul_b = C_SECS_DAY;
            end
            S_HOUR: begin
                w_mul_a = 25'(r_acc[16:4]);
                w_mul_b = C_RCP_HOUR;
            end
            S_HOUR_REM: begin
                w_mul_a = 25'(r_hour);
                w_mul_b = C_SECS_HOUR;
            end
            S_MIN: begin
                w_mul_a = 25'(r_acc[11:2]);
                w_mul_b = C_RCP_MIN;
            end
            S_MIN_REM: begin
                w_mul_a = 25'(r_min);
                w_mul_b = C_SECS_MIN;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Operand selection for the shared compare-subtract unit.
    assign w_leap = f_is_leap(r_year);

    always_comb begin
        case (r_state)
            S_DAY_REM, S_HOUR_REM, S_MIN_REM: begin
                w_oper = w_prod[W_ACC-1:0];
            end
            S_YEAR: begin
                w_oper = W_ACC'(w_leap ? C_DAYS_LEAP_YEAR : C_DAYS_YEAR);
            end
            S_MONTH: begin
                w_oper = W_ACC'(f_month_len(r_month, w_leap));
            end
            default: begin
                w_oper = '0;
            end
        endcase
    end

    es2d_sub_unit u_sub (
        .i_a    (r_acc),
        .i_b    (w_oper),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_days  = r_days;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_year  = r_year;
        n_month = r_month;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_acc   = i_epoch_seconds;
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                n_days  = w_prod[50:35];
                n_state = S_DAY_REM;
            end
            S_DAY_REM: begin
                // Seconds within the day.
                n_acc   = w_diff;
                n_state = S_HOUR;
            end
            S_HOUR: begin
                n_hour  = w_prod[25:21];
                n_state = S_HOUR_REM;
            end
            S_HOUR_REM: begin
                // Seconds within the hour.
                n_acc   = w_diff;
                n_state = S_MIN;
            end
            S_MIN: begin
                n_min   = w_prod[19:14];
                n_state = S_MIN_REM;
            end
            S_MIN_REM: begin
                n_sec   = w_diff[5:0];
                n_acc   = W_ACC'(r_days);
                n_year  = C_EPOCH_YEAR;
                n_state = S_YEAR;
            end
            S_YEAR: begin
                // Remove one whole year per cycle.
                if (w_ge) begin
                    n_acc  = w_diff;
                    n_year = r_year + 12'd1;
                end else begin
                    n_month = 4'd1;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                // Remove one whole month per cycle; December always ends it.
                if (w_ge && (r_month != 4'd12)) begin
                    n_acc   = w_diff;
                    n_month = r_month + 4'd1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_days  <= n_days;
        r_hour  <= n_hour;
        r_min   <= n_min;
        r_sec   <= n_sec;
        r_year  <= n_year;
        r_month <= n_month;
    end

    // Output register, loaded when the conversion is done and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_o_sec   <= r_sec;
            r_o_min   <= r_min;
            r_o_day   <= r_acc[4:0] + 5'd1;
            r_o_month <= r_month;
            r_o_year  <= r_year;
            // Twelve-hour form: afternoon hours fold down, noon and later set PM.
            if (r_twelve && (r_hour >= 5'd12)) begin
                r_o_pm   <= 1'b1;
                r_o_hour <= (r_hour > 5'd12) ? (r_hour - 5'd12) : r_hour;
            end else begin
                r_o_pm   <= 1'b0;
                r_o_hour <= r_hour;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_second       = r_o_sec;
    assign o_minute       = r_o_min;
    assign o_hour         = r_o_hour;
    assign o_pm_flag      = r_o_pm;
    assign o_day_of_month = r_o_day;
    assign o_month_number = r_o_month;
    assign o_year_number  = r_o_year;

endmodule

`default_nettype wire

[rtl/es2d_sub_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module es2d_sub_unit (
    input  wire logic [es2d_pkg::W_ACC-1:0] i_a,
    input  wire logic [es2d_pkg::W_ACC-1:0] i_b,
    output logic                            o_ge,
    output logic [es2d_pkg::W_ACC-1:0]      o_diff
);
    import es2d_pkg::*;

    logic [W_ACC:0] w_diff;

    // One wide subtract; the borrow out tells whether a is below b.
    assign w_diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_diff[W_ACC];
    assign o_diff = w_diff[W_ACC-1:0];

endmodule

`default_nettype wire
